// ===== rtl/fwx_pkg.sv =====
// Package for the frame word extractor with sequence check.
// Holds widths, reset values, register indexes and the result record types.
// No dependencies.
`default_nettype none

package fwx_pkg;

  localparam int WORD_BYTES_DEF    = 5;
  localparam int TRAILER_BYTES_DEF = 4;
  localparam int FIXED_OVERHEAD    = 14;

  localparam int WORD_W     = 40;
  localparam int SEQ_W      = 16;
  localparam int LEN_W      = 16;
  localparam int HDR_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic              CHECK_ENABLE_RST = 1'b1;
  localparam logic [WORD_W-1:0] IDLE_PATTERN_RST = {WORD_W{1'b1}};
  localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 6'd14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_ENABLE = 2'd0,
    REG_IDLE_PATTERN = 2'd1,
    REG_HEADER_BYTES = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_WORD   = 1'b0,
    KIND_REPORT = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic              result_kind;
    logic [WORD_W-1:0] word_data;
    logic [SEQ_W-1:0]  sequence_number;
    logic              sequence_gap;
    logic [SEQ_W-1:0]  missing_count;
    logic              last_of_run;
  } result_t;

  typedef struct packed {
    logic    word_valid;
    logic    report_valid;
    result_t word_res;
    result_t report_res;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/fwx_if.sv =====
// Request channel interfaces for the frame word extractor.
// Depends on fwx_pkg for field widths.
`default_nettype none

interface fwx_in_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 data_byte;
  logic                       start_of_frame;
  logic [fwx_pkg::LEN_W-1:0]  frame_length;

  modport source (output valid, data_byte, start_of_frame, frame_length, input ready);
  modport sink   (input valid, data_byte, start_of_frame, frame_length, output ready);
endinterface

interface fwx_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [fwx_pkg::WORD_W-1:0]  word_data;
  logic [fwx_pkg::SEQ_W-1:0]   sequence_number;
  logic                        sequence_gap;
  logic [fwx_pkg::SEQ_W-1:0]   missing_count;
  logic                        last_of_run;

  modport source (output valid, result_kind, word_data, sequence_number, sequence_gap,
                  missing_count, last_of_run, input ready);
  modport sink   (input valid, result_kind, word_data, sequence_number, sequence_gap,
                  missing_count, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/fwx_core.sv =====
// Frame parser: config registers, byte position, word packing and sequence check.
// Produces up to two results per accepted byte. Depends on fwx_pkg.
`default_nettype none

module fwx_core #(
  parameter int WORD_BYTES    = fwx_pkg::WORD_BYTES_DEF,
  parameter int TRAILER_BYTES = fwx_pkg::TRAILER_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [fwx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fwx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            accept,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            start_of_frame,
  input  wire logic [fwx_pkg::LEN_W-1:0]       frame_length,
  output fwx_pkg::push_t                       push
);
  import fwx_pkg::*;

  localparam int WW     = WORD_BYTES * 8;
  localparam int FILL_W = $clog2(WORD_BYTES + 1);
  localparam int OVH    = FIXED_OVERHEAD + TRAILER_BYTES;

  logic              check_en_r;
  logic [WORD_W-1:0] idle_r;
  logic [HDR_W-1:0]  hdr_r;

  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [WW-1:0]     shift_r, shift_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              active_r, active_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [SEQ_W-1:0]  prev_r, prev_nxt;
  logic              prev_v_r, prev_v_nxt;

  logic [LEN_W-1:0]  pos;
  logic              act0, start, act1, done, last, second_last, gap;
  logic [FILL_W-1:0] fill0, fill1, fill2;
  logic [WW-1:0]     shift0, shift1, shift2, idle_cmp;
  logic [WW+7:0]     cat;
  logic [63:0]       word_ext, idle_ext;
  logic [7:0]        hi0;
  logic [17:0]       lhs, rhs;
  logic [SEQ_W-1:0]  seq, miss;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_en_r <= CHECK_ENABLE_RST;
      idle_r     <= IDLE_PATTERN_RST;
      hdr_r      <= HEADER_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_ENABLE: check_en_r <= cfg_wdata[0];
        REG_IDLE_PATTERN: idle_r     <= cfg_wdata[WORD_W-1:0];
        REG_HEADER_BYTES: hdr_r      <= cfg_wdata[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos    = start_of_frame ? '0 : pos_r;
    act0   = start_of_frame ? 1'b0 : active_r;
    fill0  = start_of_frame ? '0 : fill_r;
    shift0 = start_of_frame ? '0 : shift_r;
    hi0    = start_of_frame ? '0 : hi_r;

    lhs   = 18'(pos) + 18'(OVH);
    rhs   = 18'(hdr_r) + 18'(frame_length);
    start = !act0 && (pos >= LEN_W'(hdr_r)) && (lhs < rhs) && (pos < frame_length);

    act1   = act0 | start;
    fill1  = start ? '0 : fill0;
    shift1 = start ? '0 : shift0;

    cat      = {shift1, data_byte};
    shift2   = act1 ? cat[WW-1:0] : shift1;
    fill2    = act1 ? fill1 + FILL_W'(1) : fill1;
    done     = act1 && (fill2 >= FILL_W'(WORD_BYTES));
    idle_ext = 64'(idle_r);
    idle_cmp = idle_ext[WW-1:0];
    word_ext = 64'(shift2);

    last        = (17'(pos) + 17'd1) == 17'(frame_length);
    second_last = (17'(pos) + 17'd2) == 17'(frame_length);
    hi_nxt      = second_last ? data_byte : hi0;

    seq  = {hi_nxt, data_byte};
    gap  = check_en_r && prev_v_r && (seq != prev_r + SEQ_W'(1));
    miss = gap ? seq - prev_r - SEQ_W'(1) : '0;

    shift_nxt  = shift2;
    active_nxt = act1 && !done && !last;
    fill_nxt   = (done || last) ? '0 : fill2;
    prev_nxt   = last ? seq : prev_r;
    prev_v_nxt = prev_v_r | last;
    pos_nxt    = (pos != {LEN_W{1'b1}}) ? pos + LEN_W'(1) : pos;

    push.report_valid               = last;
    push.word_valid                 = done && (shift2 != idle_cmp);
    push.word_res.result_kind       = KIND_WORD;
    push.word_res.word_data         = word_ext[WORD_W-1:0];
    push.word_res.sequence_number   = '0;
    push.word_res.sequence_gap      = 1'b0;
    push.word_res.missing_count     = '0;
    push.word_res.last_of_run       = !last;
    push.report_res.result_kind     = KIND_REPORT;
    push.report_res.word_data       = '0;
    push.report_res.sequence_number = seq;
    push.report_res.sequence_gap    = gap;
    push.report_res.missing_count   = miss;
    push.report_res.last_of_run     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fill_r   <= '0;
      active_r <= 1'b0;
      hi_r     <= '0;
      prev_r   <= '0;
      prev_v_r <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      fill_r   <= fill_nxt;
      active_r <= active_nxt;
      hi_r     <= hi_nxt;
      prev_r   <= prev_nxt;
      prev_v_r <= prev_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shift_r <= shift_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fwx_outq.sv =====
// Result queue: four registered entries, takes up to two results a cycle, gives one.
// Depends on fwx_pkg.
`default_nettype none

module fwx_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire fwx_pkg::push_t push,
  output logic                room,
  output logic                head_valid,
  output fwx_pkg::result_t    head,
  input  wire logic           pop
);
  import fwx_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;
  logic [1:0]       n_push;

  assign room       = count_r <= CNT_W'(DEPTH - 2);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    n_push    = accept ? 2'(push.word_valid) + 2'(push.report_valid) : 2'd0;
    wptr_nxt  = wptr_r + PTR_W'(n_push);
    rptr_nxt  = do_pop ? rptr_r + PTR_W'(1) : rptr_r;
    count_nxt = count_r + CNT_W'(n_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (push.word_valid) begin
        mem_r[wptr_r] <= push.word_res;
        if (push.report_valid) begin
          mem_r[wptr_r + PTR_W'(1)] <= push.report_res;
        end
      end else if (push.report_valid) begin
        mem_r[wptr_r] <= push.report_res;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frame_word_extract_seq_check.sv =====
// Top level of the frame word extractor with sequence continuity check.
// Instantiates fwx_core and fwx_outq; depends on fwx_pkg and fwx_if.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    data_byte, start_of_frame, frame_length
//   out_chan  out  valid/ready    result_kind, word_data, sequence_number,
//                                 sequence_gap, missing_count, last_of_run
//   cfg_*     in   cfg_we only    cfg_index, cfg_wdata
//
// One byte per cycle; each byte is parsed in the cycle it is taken and its
// results land in a four-entry result queue, registered there before they reach
// out_chan. A frame's last byte may give two results, draining one per cycle
// while out_chan.ready is high. in_chan.ready drops while the queue holds more
// than two results. Reset is synchronous; no clearing pass.
`default_nettype none

module frame_word_extract_seq_check #(
  parameter int WORD_BYTES    = fwx_pkg::WORD_BYTES_DEF,
  parameter int TRAILER_BYTES = fwx_pkg::TRAILER_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fwx_in_if.sink                               in_chan,
  fwx_out_if.source                            out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [fwx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fwx_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fwx_pkg::*;

  push_t   push;
  result_t head;
  logic    room, head_valid, accept;

  assign in_chan.ready = room;
  assign accept        = in_chan.valid && room;

  fwx_core #(
    .WORD_BYTES    (WORD_BYTES),
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .accept         (accept),
    .data_byte      (in_chan.data_byte),
    .start_of_frame (in_chan.start_of_frame),
    .frame_length   (in_chan.frame_length),
    .push           (push)
  );

  fwx_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_chan.ready)
  );

  assign out_chan.valid           = head_valid;
  assign out_chan.result_kind     = head.result_kind;
  assign out_chan.word_data       = head.word_data;
  assign out_chan.sequence_number = head.sequence_number;
  assign out_chan.sequence_gap    = head.sequence_gap;
  assign out_chan.missing_count   = head.missing_count;
  assign out_chan.last_of_run     = head.last_of_run;

endmodule

`default_nettype wire

// ===== rtl/fwx_checker.sv =====
// Port-level checks for frame_word_extract_seq_check, attached by bind.
// Depends on fwx_pkg.
`default_nettype none

module fwx_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        result_kind,
  input wire logic [fwx_pkg::WORD_W-1:0]  word_data,
  input wire logic [fwx_pkg::SEQ_W-1:0]   sequence_number,
  input wire logic                        sequence_gap,
  input wire logic [fwx_pkg::SEQ_W-1:0]   missing_count,
  input wire logic                        last_of_run
);
  import fwx_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(word_data) && $stable(sequence_number)
      && $stable(result_kind))
    else $error("result request changed while stalled");

  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_REPORT |-> last_of_run && word_data == '0)
    else $error("report not closing its run");

  a_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == KIND_WORD |->
      sequence_number == '0 && !sequence_gap && missing_count == '0)
    else $error("word result carries report fields");

  a_no_gap_no_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !sequence_gap |-> missing_count == '0)
    else $error("missing count without gap");

endmodule

bind frame_word_extract_seq_check fwx_checker u_fwx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .result_kind     (out_chan.result_kind),
  .word_data       (out_chan.word_data),
  .sequence_number (out_chan.sequence_number),
  .sequence_gap    (out_chan.sequence_gap),
  .missing_count   (out_chan.missing_count),
  .last_of_run     (out_chan.last_of_run)
);

`default_nettype wire
